// ----- rtl/mips_subset_alu_regfile_assert.svh -----
// Assertion macros for the MIPS subset ALU with register file.
// Included inside module bodies that check their own control logic.
`ifndef MIPS_SUBSET_ALU_REGFILE_ASSERT_SVH
`define MIPS_SUBSET_ALU_REGFILE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MSAR_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MSAR_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/msar_pkg.sv -----
// Shared types and constants for the MIPS subset ALU with register file.
// No dependencies; imported by the top level.
package msar_pkg;

   localparam int DEF_REG_COUNT  = 32;
   localparam int DEF_DATA_WIDTH = 32;

   localparam int KIND_W      = 4;
   localparam int REG_FIELD_W = 5;
   localparam int IMM_W       = 32;
   localparam int VALUE_W     = 32;

   // number of distinct codes a register field can carry
   localparam int REG_FIELD_SPAN = 2 ** REG_FIELD_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD  = 4'd0,
      KIND_ADDI = 4'd1,
      KIND_AND  = 4'd2,
      KIND_ANDI = 4'd3,
      KIND_OR   = 4'd4,
      KIND_ORI  = 4'd5,
      KIND_SLT  = 4'd6,
      KIND_SLTI = 4'd7,
      KIND_BEQ  = 4'd8,
      KIND_BNE  = 4'd9
   } kind_type;

   typedef struct packed {
      logic [KIND_W-1:0]      kind;
      logic [REG_FIELD_W-1:0] dest_reg;
      logic [REG_FIELD_W-1:0] first_reg;
      logic [REG_FIELD_W-1:0] second_reg;
      logic signed [IMM_W-1:0] immediate;
      logic                   imm_is_first;
   } req_type;

   typedef struct packed {
      logic                      wrote;
      logic signed [VALUE_W-1:0] written_value;
      logic                      taken;
   } rsp_type;

endpackage

// ----- rtl/msar_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module msar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read returns the old contents on a same-address write
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/mips_subset_alu_regfile.sv -----
// MIPS subset ALU with register file: executes add, and, or and slt (register and
// immediate forms, immediate on either side) plus beq/bne against REG_COUNT registers
// of DATA_WIDTH bits, all zero after reset. Throughput is one instruction per clock
// while rsp_ready drains the response register; a stall holds the execute stage. An
// accepted request passes the registered read of the register-file RAM, then execute
// into the response register. The next instruction may read a register written by the
// one just before it: that value is forwarded from the last-write register. Register
// indexes are taken modulo REG_COUNT; undefined kinds write nothing and return all-zero
// fields. Depends on msar_pkg, msar_ram and mips_subset_alu_regfile_assert.svh.
module mips_subset_alu_regfile #(
   parameter int REG_COUNT  = msar_pkg::DEF_REG_COUNT,
   parameter int DATA_WIDTH = msar_pkg::DEF_DATA_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  msar_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msar_pkg::rsp_type rsp_data
);

   import msar_pkg::*;

`include "mips_subset_alu_regfile_assert.svh"

   localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   // wide enough for both the immediate and the data path
   localparam int EXT_W = (DATA_WIDTH > IMM_W) ? DATA_WIDTH : IMM_W;

   // register field code -> file index, i.e. code modulo REG_COUNT
   typedef logic [IDX_W-1:0] idx_lut_type [REG_FIELD_SPAN];

   function automatic idx_lut_type build_idx_lut();
      idx_lut_type lut;
      int unsigned cnt;
      cnt = 0;
      for (int i = 0; i < REG_FIELD_SPAN; i++) begin
         lut[i] = IDX_W'(cnt);
         cnt    = (cnt == REG_COUNT - 1) ? 0 : cnt + 1;
      end
      return lut;
   endfunction

   localparam idx_lut_type IDX_LUT = build_idx_lut();

   // ---------------------------------------------------------------
   // Handshake and stage control
   // ---------------------------------------------------------------
   logic req_fire;
   logic s1_adv;

   logic s1_vld_ff;
   logic out_vld_ff;

   // advance execute into the response register when it is empty or being drained
   assign s1_adv    = s1_vld_ff & (~out_vld_ff | rsp_ready);
   assign req_ready = ~s1_vld_ff | s1_adv;
   assign req_fire  = req_valid & req_ready;

   // ---------------------------------------------------------------
   // Register file read (issued at accept, data valid in execute)
   // ---------------------------------------------------------------
   logic [IDX_W-1:0] req_a_idx;
   logic [IDX_W-1:0] req_b_idx;
   logic [IDX_W-1:0] req_d_idx;

   assign req_a_idx = IDX_LUT[req_data.first_reg];
   assign req_b_idx = IDX_LUT[req_data.second_reg];
   assign req_d_idx = IDX_LUT[req_data.dest_reg];

   logic [DATA_WIDTH-1:0] ram_a_data;
   logic [DATA_WIDTH-1:0] ram_b_data;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_idx;
   logic [DATA_WIDTH-1:0] wr_data;

   // two copies of the file, written alike, give two read ports
   msar_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (REG_COUNT)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_a_idx),
      .rd_data (ram_a_data)
   );

   msar_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (REG_COUNT)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_b_idx),
      .rd_data (ram_b_data)
   );

   // Per-entry written flags: an entry never written since reset reads as zero.
   logic [REG_COUNT-1:0] reg_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
      end else if (wr_en) begin
         reg_vld_ff[wr_idx] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Execute stage registers
   // ---------------------------------------------------------------
   req_type          s1_req_ff;
   logic [IDX_W-1:0] s1_a_idx_ff;
   logic [IDX_W-1:0] s1_b_idx_ff;
   logic [IDX_W-1:0] s1_dst_ff;
   logic             s1_a_vld_ff;
   logic             s1_b_vld_ff;

   logic s1_vld_in;
   assign s1_vld_in = req_fire | (s1_vld_ff & ~s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
      // capture payload and written flags alongside the RAM read
      if (req_fire) begin
         s1_req_ff   <= req_data;
         s1_a_idx_ff <= req_a_idx;
         s1_b_idx_ff <= req_b_idx;
         s1_dst_ff   <= req_d_idx;
         s1_a_vld_ff <= reg_vld_ff[req_a_idx];
         s1_b_vld_ff <= reg_vld_ff[req_b_idx];
      end
   end

   // Last-write register: the write that landed in the same edge as this
   // instruction's RAM read is missed by the read, so forward it.
   logic                  fwd_vld_ff;
   logic [IDX_W-1:0]      fwd_idx_ff;
   logic [DATA_WIDTH-1:0] fwd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (wr_en) begin
         fwd_vld_ff <= 1'b1;
      end
      if (wr_en) begin
         fwd_idx_ff  <= wr_idx;
         fwd_data_ff <= wr_data;
      end
   end

   // ---------------------------------------------------------------
   // Execute
   // ---------------------------------------------------------------
   logic [DATA_WIDTH-1:0] reg_a;
   logic [DATA_WIDTH-1:0] reg_b;
   logic [EXT_W-1:0]      imm_ext;
   logic [DATA_WIDTH-1:0] imm_val;
   logic                  imm_form;
   logic [DATA_WIDTH-1:0] opa;
   logic [DATA_WIDTH-1:0] opb;
   logic [DATA_WIDTH-1:0] res_value;
   logic                  res_wrote;
   logic                  res_taken;
   logic [EXT_W-1:0]      res_ext;
   rsp_type               res_rsp;

   always_comb begin
      // pick forwarded data, else RAM data, else the reset value
      if (fwd_vld_ff && (fwd_idx_ff == s1_a_idx_ff)) begin
         reg_a = fwd_data_ff;
      end else begin
         reg_a = s1_a_vld_ff ? ram_a_data : '0;
      end
      if (fwd_vld_ff && (fwd_idx_ff == s1_b_idx_ff)) begin
         reg_b = fwd_data_ff;
      end else begin
         reg_b = s1_b_vld_ff ? ram_b_data : '0;
      end

      // sign-extend the immediate, then fit it to the data path
      imm_ext = EXT_W'(s1_req_ff.immediate);
      imm_val = imm_ext[DATA_WIDTH-1:0];

      // odd kinds below beq are the immediate forms
      imm_form = (s1_req_ff.kind < KIND_BEQ) && s1_req_ff.kind[0];
      opa      = (imm_form && s1_req_ff.imm_is_first)  ? imm_val : reg_a;
      opb      = (imm_form && !s1_req_ff.imm_is_first) ? imm_val : reg_b;

      res_value = '0;
      res_wrote = 1'b0;
      res_taken = 1'b0;
      case (s1_req_ff.kind)
         KIND_ADD, KIND_ADDI: begin
            res_value = opa + opb;
            res_wrote = 1'b1;
         end
         KIND_AND, KIND_ANDI: begin
            res_value = opa & opb;
            res_wrote = 1'b1;
         end
         KIND_OR, KIND_ORI: begin
            res_value = opa | opb;
            res_wrote = 1'b1;
         end
         KIND_SLT, KIND_SLTI: begin
            res_value = DATA_WIDTH'($signed(opa) < $signed(opb));
            res_wrote = 1'b1;
         end
         KIND_BEQ: begin
            res_taken = (opa == opb);
         end
         KIND_BNE: begin
            res_taken = (opa != opb);
         end
         default: begin
            // undefined kind: no write, all-zero result
            res_value = '0;
         end
      endcase

      // report the value zero-extended or cut to the result field
      res_ext               = EXT_W'(res_value);
      res_rsp.wrote         = res_wrote;
      res_rsp.written_value = res_ext[VALUE_W-1:0];
      res_rsp.taken         = res_taken;
   end

   // write back as the instruction leaves execute
   assign wr_en   = s1_adv & res_wrote;
   assign wr_idx  = s1_dst_ff;
   assign wr_data = res_value;

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   rsp_type out_data_ff;
   logic    out_vld_in;

   assign out_vld_in = s1_adv | (out_vld_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      if (s1_adv) begin
         out_data_ff <= res_rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `MSAR_ASSERT_NOW(a_hold_when_blocked, clock, reset,
      s1_vld_ff && out_vld_ff && !rsp_ready, !req_ready,
      "request accepted while execute stage is blocked")

   `MSAR_ASSERT_NEXT(a_fwd_tracks_write, clock, reset,
      wr_en, fwd_vld_ff && (fwd_idx_ff == $past(wr_idx)),
      "last-write register does not follow the register write")

   `MSAR_ASSERT_NEXT(a_written_flag_set, clock, reset,
      wr_en, reg_vld_ff[$past(wr_idx)],
      "written register not flagged as written")

   `MSAR_ASSERT_NOW(a_branch_no_write, clock, reset,
      s1_adv && res_taken, !wr_en,
      "branch outcome reported together with a register write")

endmodule
